/* rtl/jddr_pkg.sv */
`timescale 1ns / 1ps

package jddr_pkg;

	// Zone codes reported with each result
	typedef enum logic [3:0] {
		ZONE_MID        = 4'd0,
		ZONE_RIGHT      = 4'd1,
		ZONE_LEFT       = 4'd2,
		ZONE_FWD        = 4'd3,
		ZONE_BACK       = 4'd4,
		ZONE_RIGHT_FWD  = 4'd5,
		ZONE_LEFT_FWD   = 4'd6,
		ZONE_RIGHT_BACK = 4'd7,
		ZONE_LEFT_BACK  = 4'd8
	} zone_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_DEAD_ZONE   = 2'd0,
		CFG_UPPER_LIMIT = 2'd1,
		CFG_LOWER_LIMIT = 2'd2
	} cfg_idx_t;

	localparam int unsigned DZ_W   = 7;
	localparam int unsigned DRV_W  = 8;
	localparam int unsigned STK_W  = 8;
	localparam int unsigned CFG_W  = 8;

	localparam logic [DZ_W-1:0]         DZ_RST    = 7'd20;
	localparam logic signed [DRV_W-1:0] UPPER_RST = 8'sd122;
	localparam logic signed [DRV_W-1:0] LOWER_RST = -8'sd121;

	typedef logic signed [DRV_W-1:0] drive_t;

	// Limits handed to the ramp logic
	typedef struct packed {
		drive_t upper;
		drive_t lower;
	} limits_t;

	// Step up only while below the upper limit
	function automatic drive_t step_up(input drive_t d, input drive_t lim);
		step_up = (d < lim) ? drive_t'(d + 8'sd1) : d;
	endfunction

	// Step down only while above the lower limit
	function automatic drive_t step_down(input drive_t d, input drive_t lim);
		step_down = (d > lim) ? drive_t'(d - 8'sd1) : d;
	endfunction

endpackage

/* rtl/jddr_zone.sv */
`timescale 1ns / 1ps

module jddr_zone (
	input  logic signed [jddr_pkg::STK_W-1:0] x,
	input  logic signed [jddr_pkg::STK_W-1:0] y,
	input  logic        [jddr_pkg::DZ_W-1:0]  dead_zone,
	output jddr_pkg::zone_t                   zone
);

	logic signed [jddr_pkg::STK_W:0] x9, y9, dz_p, dz_n;
	logic xc, yc, xp, xn, yp, yn;

	// Widen by one bit so the negated dead zone fits
	assign x9   = {x[jddr_pkg::STK_W-1], x};
	assign y9   = {y[jddr_pkg::STK_W-1], y};
	assign dz_p = {2'b00, dead_zone};
	assign dz_n = -dz_p;

	assign xc = (x9 > dz_n) && (x9 < dz_p);
	assign yc = (y9 > dz_n) && (y9 < dz_p);
	assign xp = x9 >= dz_p;
	assign xn = x9 <= dz_n;
	assign yp = y9 >= dz_p;
	assign yn = y9 <= dz_n;

	// Classify in priority order; first match wins
	always_comb begin
		if (xc && yc)      zone = jddr_pkg::ZONE_MID;
		else if (xp && yp) zone = jddr_pkg::ZONE_RIGHT_FWD;
		else if (xp && yn) zone = jddr_pkg::ZONE_RIGHT_BACK;
		else if (xn && yp) zone = jddr_pkg::ZONE_LEFT_FWD;
		else if (xn && yn) zone = jddr_pkg::ZONE_LEFT_BACK;
		else if (xc && yp) zone = jddr_pkg::ZONE_FWD;
		else if (xc && yn) zone = jddr_pkg::ZONE_BACK;
		else if (xp && yc) zone = jddr_pkg::ZONE_RIGHT;
		else if (xn && yc) zone = jddr_pkg::ZONE_LEFT;
		else               zone = jddr_pkg::ZONE_MID;
	end

endmodule

/* rtl/jddr_ramp.sv */
`timescale 1ns / 1ps

module jddr_ramp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  jddr_pkg::zone_t     zone,
	input  jddr_pkg::limits_t   lim,
	output jddr_pkg::drive_t    right_nxt,
	output jddr_pkg::drive_t    left_nxt
);

	jddr_pkg::drive_t right_q, left_q;
	jddr_pkg::drive_t r1, r2, l1, l2;

	// Next drives for each zone; the diagonals double-step one drive
	always_comb begin
		r1 = right_q;
		r2 = right_q;
		l1 = left_q;
		l2 = left_q;
		right_nxt = right_q;
		left_nxt  = left_q;
		unique case (zone)
			jddr_pkg::ZONE_FWD: begin
				right_nxt = jddr_pkg::step_up(right_q, lim.upper);
				left_nxt  = jddr_pkg::step_up(left_q, lim.upper);
			end
			jddr_pkg::ZONE_LEFT: begin
				right_nxt = jddr_pkg::step_up(right_q, lim.upper);
				left_nxt  = jddr_pkg::step_down(left_q, lim.lower);
			end
			jddr_pkg::ZONE_RIGHT: begin
				right_nxt = jddr_pkg::step_down(right_q, lim.lower);
				left_nxt  = jddr_pkg::step_up(left_q, lim.upper);
			end
			jddr_pkg::ZONE_BACK: begin
				right_nxt = jddr_pkg::step_down(right_q, lim.lower);
				left_nxt  = jddr_pkg::step_down(left_q, lim.lower);
			end
			jddr_pkg::ZONE_LEFT_FWD: begin
				r1 = jddr_pkg::step_up(right_q, lim.upper);
				r2 = jddr_pkg::step_up(r1, lim.upper);
				right_nxt = r2;
				left_nxt  = (r2 < lim.upper) ? jddr_pkg::step_up(left_q, lim.upper)
				                             : jddr_pkg::step_down(left_q, lim.lower);
			end
			jddr_pkg::ZONE_RIGHT_FWD: begin
				l1 = jddr_pkg::step_up(left_q, lim.upper);
				l2 = jddr_pkg::step_up(l1, lim.upper);
				left_nxt  = l2;
				right_nxt = (l2 < lim.upper) ? jddr_pkg::step_up(right_q, lim.upper)
				                             : jddr_pkg::step_down(right_q, lim.lower);
			end
			jddr_pkg::ZONE_LEFT_BACK: begin
				l1 = jddr_pkg::step_down(left_q, lim.lower);
				l2 = jddr_pkg::step_down(l1, lim.lower);
				left_nxt  = l2;
				right_nxt = (l2 > lim.lower) ? jddr_pkg::step_down(right_q, lim.lower)
				                             : jddr_pkg::step_up(right_q, lim.upper);
			end
			jddr_pkg::ZONE_RIGHT_BACK: begin
				r1 = jddr_pkg::step_down(right_q, lim.lower);
				r2 = jddr_pkg::step_down(r1, lim.lower);
				right_nxt = r2;
				left_nxt  = (r2 > lim.lower) ? jddr_pkg::step_down(left_q, lim.lower)
				                             : jddr_pkg::step_up(left_q, lim.upper);
			end
			default: begin
				// Hold both drives in the middle zone
				right_nxt = right_q;
				left_nxt  = left_q;
			end
		endcase
	end

	// Commit the drives when a request moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= '0;
			left_q  <= '0;
		end else if (upd) begin
			right_q <= right_nxt;
			left_q  <= left_nxt;
		end
	end

endmodule

/* rtl/joystick_differential_drive_ramp_unit.sv */
`timescale 1ns / 1ps

// Joystick differential-drive ramp. Each request is one signed stick sample;
// it is sorted into one of nine zones (deadband, four axes, four diagonals)
// and the kept right and left drive values are ramped in single or double steps within
// upper_limit/lower_limit. One request is taken every cycle while in_stall is low;
// its result passes through the input register and then the result register,
// and the drives update in the one pass from the input register to the
// result register. Both drives reset to zero. Write the configuration
// registers (0 dead_zone, 1 upper_limit, 2 lower_limit) only while the block
// is idle.
module joystick_differential_drive_ramp_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [jddr_pkg::STK_W-1:0] stick_x,
	input  logic signed [jddr_pkg::STK_W-1:0] stick_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic        [3:0]                 zone,
	output logic signed [jddr_pkg::DRV_W-1:0] right_drive_out,
	output logic signed [jddr_pkg::DRV_W-1:0] left_drive_out,
	input  logic                              cfg_wen,
	input  logic        [1:0]                 cfg_addr,
	input  logic        [jddr_pkg::CFG_W-1:0] cfg_wdata
);

	logic [jddr_pkg::DZ_W-1:0] dead_zone_q;
	jddr_pkg::limits_t         lim_q;

	logic                              valid_s1;
	logic signed [jddr_pkg::STK_W-1:0] x_s1, y_s1;
	logic                              valid_s2;
	jddr_pkg::zone_t                   zone_s2;
	jddr_pkg::drive_t                  right_s2, left_s2;

	logic             adv_s2, adv_s1;
	jddr_pkg::zone_t  zone_c;
	jddr_pkg::drive_t right_c, left_c;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= jddr_pkg::DZ_RST;
			lim_q.upper <= jddr_pkg::UPPER_RST;
			lim_q.lower <= jddr_pkg::LOWER_RST;
		end else if (cfg_wen) begin
			unique case (jddr_pkg::cfg_idx_t'(cfg_addr))
				jddr_pkg::CFG_DEAD_ZONE:   dead_zone_q <= cfg_wdata[jddr_pkg::DZ_W-1:0];
				jddr_pkg::CFG_UPPER_LIMIT: lim_q.upper <= cfg_wdata;
				jddr_pkg::CFG_LOWER_LIMIT: lim_q.lower <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: result stage frees when empty or taken
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			x_s1 <= stick_x;
			y_s1 <= stick_y;
		end
	end

	jddr_zone u_zone (
		.x         (x_s1),
		.y         (y_s1),
		.dead_zone (dead_zone_q),
		.zone      (zone_c)
	);

	jddr_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (adv_s1),
		.zone      (zone_c),
		.lim       (lim_q),
		.right_nxt (right_c),
		.left_nxt  (left_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			zone_s2  <= zone_c;
			right_s2 <= right_c;
			left_s2  <= left_c;
		end
	end

	assign out_valid       = valid_s2;
	assign zone            = zone_s2;
	assign right_drive_out = right_s2;
	assign left_drive_out  = left_s2;

endmodule

/* bench/tb_joystick_differential_drive_ramp_unit.sv */
`timescale 1ns / 1ps

module tb_joystick_differential_drive_ramp_unit;

	typedef struct {
		jddr_pkg::zone_t  zone;
		jddr_pkg::drive_t right;
		jddr_pkg::drive_t left;
	} drive_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic signed [jddr_pkg::STK_W-1:0] stick_x;
	logic signed [jddr_pkg::STK_W-1:0] stick_y;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [3:0]                        zone;
	logic signed [jddr_pkg::DRV_W-1:0] right_drive_out;
	logic signed [jddr_pkg::DRV_W-1:0] left_drive_out;
	logic                              cfg_wen;
	logic [1:0]                        cfg_addr;
	logic [jddr_pkg::CFG_W-1:0]        cfg_wdata;

	// Predicted drive state and register copy
	int dz_cfg = 20;
	int up_lim = 122;
	int lo_lim = -121;
	int right_drv = 0;
	int left_drv = 0;

	drive_result_t expected_q[$];
	drive_result_t head_r;

	int send_gap_max = 13;
	int recv_wait_max = 13;
	int hold_req = 0;
	int hold_left = 0;
	int wait_left = 0;

	int n_err = 0;
	int n_samples = 0;
	int n_checked = 0;
	int n_settings = 1;
	int zone_hits[9];

	joystick_differential_drive_ramp_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.stick_x         (stick_x),
		.stick_y         (stick_y),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.zone            (zone),
		.right_drive_out (right_drive_out),
		.left_drive_out  (left_drive_out),
		.cfg_wen         (cfg_wen),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Guarded single steps of one drive
	function automatic int drive_inc(int d);
		return (d < up_lim) ? d + 1 : d;
	endfunction

	function automatic int drive_dec(int d);
		return (d > lo_lim) ? d - 1 : d;
	endfunction

	// Sort a sample into its zone; first matching test wins
	function automatic jddr_pkg::zone_t zone_of(int x, int y);
		bit xc, yc, xp, xn, yp, yn;
		xc = (x > -dz_cfg) && (x < dz_cfg);
		yc = (y > -dz_cfg) && (y < dz_cfg);
		xp = x >= dz_cfg;
		xn = x <= -dz_cfg;
		yp = y >= dz_cfg;
		yn = y <= -dz_cfg;
		if (xc && yc) return jddr_pkg::ZONE_MID;
		else if (xp && yp) return jddr_pkg::ZONE_RIGHT_FWD;
		else if (xp && yn) return jddr_pkg::ZONE_RIGHT_BACK;
		else if (xn && yp) return jddr_pkg::ZONE_LEFT_FWD;
		else if (xn && yn) return jddr_pkg::ZONE_LEFT_BACK;
		else if (xc && yp) return jddr_pkg::ZONE_FWD;
		else if (xc && yn) return jddr_pkg::ZONE_BACK;
		else if (xp && yc) return jddr_pkg::ZONE_RIGHT;
		else if (xn && yc) return jddr_pkg::ZONE_LEFT;
		return jddr_pkg::ZONE_MID;
	endfunction

	// Ramp the drives for one sample and queue the expected result
	function automatic void ramp_drives(int x, int y);
		jddr_pkg::zone_t z;
		drive_result_t r;
		z = zone_of(x, y);
		case (z)
			jddr_pkg::ZONE_FWD: begin
				right_drv = drive_inc(right_drv);
				left_drv = drive_inc(left_drv);
			end
			jddr_pkg::ZONE_LEFT: begin
				right_drv = drive_inc(right_drv);
				left_drv = drive_dec(left_drv);
			end
			jddr_pkg::ZONE_RIGHT: begin
				right_drv = drive_dec(right_drv);
				left_drv = drive_inc(left_drv);
			end
			jddr_pkg::ZONE_BACK: begin
				right_drv = drive_dec(right_drv);
				left_drv = drive_dec(left_drv);
			end
			jddr_pkg::ZONE_LEFT_FWD: begin
				right_drv = drive_inc(drive_inc(right_drv));
				left_drv = (right_drv < up_lim) ? drive_inc(left_drv) : drive_dec(left_drv);
			end
			jddr_pkg::ZONE_RIGHT_FWD: begin
				left_drv = drive_inc(drive_inc(left_drv));
				right_drv = (left_drv < up_lim) ? drive_inc(right_drv) : drive_dec(right_drv);
			end
			jddr_pkg::ZONE_LEFT_BACK: begin
				left_drv = drive_dec(drive_dec(left_drv));
				right_drv = (left_drv > lo_lim) ? drive_dec(right_drv) : drive_inc(right_drv);
			end
			jddr_pkg::ZONE_RIGHT_BACK: begin
				right_drv = drive_dec(drive_dec(right_drv));
				left_drv = (right_drv > lo_lim) ? drive_dec(left_drv) : drive_inc(left_drv);
			end
			default: ;
		endcase
		zone_hits[int'(z)]++;
		r.zone = z;
		r.right = jddr_pkg::drive_t'(right_drv);
		r.left = jddr_pkg::drive_t'(left_drv);
		expected_q.push_back(r);
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic send_sample(input int x, input int y);
		int gap;
		logic signed [jddr_pkg::STK_W-1:0] xs, ys;
		xs = jddr_pkg::STK_W'(x);
		ys = jddr_pkg::STK_W'(y);
		gap = $urandom_range(send_gap_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stick_x <= xs;
		stick_y <= ys;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ramp_drives(int'(xs), int'(ys));
		n_samples++;
	endtask

	// Drop the request line and wait until every result is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	// Write all three registers while the block is idle
	task automatic write_cfg(input int dz, input int up, input int lo);
		wait_idle();
		cfg_wen <= 1'b1;
		cfg_addr <= jddr_pkg::CFG_DEAD_ZONE;
		// the top bit of the dead zone word is not part of the register
		cfg_wdata <= {1'($urandom_range(1, 0)), 7'(dz)};
		@(posedge clk);
		cfg_addr <= jddr_pkg::CFG_UPPER_LIMIT;
		cfg_wdata <= 8'(up);
		@(posedge clk);
		cfg_addr <= jddr_pkg::CFG_LOWER_LIMIT;
		cfg_wdata <= 8'(lo);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		dz_cfg = dz & 127;
		up_lim = up;
		lo_lim = lo;
		n_settings++;
	endtask

	// Axis value that is deflected in direction dir, or centred for dir 0
	function automatic int axis_value(int dir);
		if (dir > 0) return int'($urandom_range(127, dz_cfg));
		if (dir < 0) return -int'($urandom_range(128, (dz_cfg == 0) ? 0 : dz_cfg));
		if (dz_cfg == 0) return 0;
		return int'($urandom_range(2 * dz_cfg - 2, 0)) - (dz_cfg - 1);
	endfunction

	// Values at the dead zone edges and the ends of the range
	function automatic int edge_value();
		case ($urandom_range(6, 0))
			0: return dz_cfg;
			1: return dz_cfg - 1;
			2: return -dz_cfg;
			3: return 1 - dz_cfg;
			4: return 127;
			5: return -128;
			default: return 0;
		endcase
	endfunction

	// Zone edges and range extremes under the reset settings
	task automatic test_zone_boundaries();
		send_sample(0, 0);
		send_sample(19, -19);
		send_sample(20, 0);
		send_sample(-20, 0);
		send_sample(0, 127);
		send_sample(0, -128);
		send_sample(127, 127);
		send_sample(-128, 127);
		send_sample(127, -128);
		send_sample(-128, -128);
		send_sample(19, 20);
	endtask

	// Diagonals against tight limits: the partner drive turns around
	task automatic test_diagonal_saturation();
		write_cfg(1, 2, -2);
		repeat (3) send_sample(127, 127);
		repeat (3) send_sample(-128, -128);
		send_sample(-100, 90);
		send_sample(90, -100);
	endtask

	// Without a dead zone no sample is centred
	task automatic test_zero_dead_zone();
		write_cfg(0, 122, -121);
		send_sample(0, 0);
		send_sample(0, -5);
		send_sample(7, 0);
		send_sample(-1, 1);
	endtask

	// Crossed limits hold the drives, widest limits let them move
	task automatic test_crossed_limits();
		write_cfg(20, -128, 127);
		send_sample(0, 127);
		send_sample(0, -128);
		write_cfg(127, 127, -128);
		send_sample(127, 127);
		send_sample(-128, -128);
	endtask

	// Long receiver hold-off while requests keep coming, then a full drain
	task automatic test_backpressure();
		write_cfg(20, 122, -121);
		send_gap_max = 0;
		recv_wait_max = 0;
		hold_req = 60;
		repeat (16) send_sample(axis_value(1), axis_value(0));
		wait_idle();
		repeat (4) send_sample(axis_value(-1), axis_value(1));
	endtask

	// Random phases: mostly runs toward one zone, some noise and edge values
	task automatic test_random_phases();
		int sent, run_len, dx, dy, dz, up, lo;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: begin
					dz = 20;
					up = 122;
					lo = -121;
				end
				1: begin
					dz = (ph < 5) ? 127 : 1;
					up = 127;
					lo = -128;
				end
				2: begin
					dz = $urandom_range(40, 1);
					up = $urandom_range(12, 0);
					lo = -int'($urandom_range(12, 0));
				end
				3: begin
					dz = $urandom_range(60, 1);
					lo = int'($urandom_range(40, 0)) - 20;
					up = lo - int'($urandom_range(10, 0));
				end
				default: begin
					dz = (ph == 9) ? 0 : $urandom_range(127, 0);
					up = int'($urandom_range(255, 0)) - 128;
					lo = int'($urandom_range(255, 0)) - 128;
				end
			endcase
			write_cfg(dz, up, lo);
			send_gap_max = (ph % 2 == 0) ? 13 : 0;
			recv_wait_max = (ph % 4 < 2) ? 13 : 0;
			sent = 0;
			while (sent < 45) begin
				case ($urandom_range(9, 0))
					7, 8: begin
						send_sample(int'($urandom_range(255, 0)) - 128,
							int'($urandom_range(255, 0)) - 128);
						sent++;
					end
					9: begin
						send_sample(edge_value(), edge_value());
						sent++;
					end
					default: begin
						dx = int'($urandom_range(2, 0)) - 1;
						dy = int'($urandom_range(2, 0)) - 1;
						run_len = $urandom_range(40, 1);
						if (run_len > 45 - sent)
							run_len = 45 - sent;
						repeat (run_len) begin
							send_sample(axis_value(dx), axis_value(dy));
							sent++;
						end
					end
				endcase
			end
		end
	endtask

	// Check each accepted result and pace the receiver's stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR %0t: result with nothing pending: %s %0d %0d %0d",
							$time, "zone/right/left", zone, right_drive_out,
							left_drive_out);
				end else begin
					head_r = expected_q.pop_front();
					n_checked++;
					if (zone !== head_r.zone || right_drive_out !== head_r.right ||
						left_drive_out !== head_r.left) begin
						n_err++;
						if (n_err <= 10) begin
							$display("ERROR %0t: exp zone %0d right %0d left %0d,",
								$time, head_r.zone, head_r.right, head_r.left);
							$display("      got zone %0d right %0d left %0d",
								zone, right_drive_out, left_drive_out);
						end
					end
				end
				wait_left = $urandom_range(recv_wait_max, 0);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			out_stall <= (hold_left > 0) || (wait_left > 0);
			if (hold_left > 0)
				hold_left--;
			else if (wait_left > 0)
				wait_left--;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		stick_x = '0;
		stick_y = '0;
		cfg_wen = 1'b0;
		cfg_addr = jddr_pkg::CFG_DEAD_ZONE;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zone_boundaries();
		test_diagonal_saturation();
		test_zero_dead_zone();
		test_crossed_limits();
		test_backpressure();
		test_random_phases();

		wait_idle();
		repeat (10) @(posedge clk);

		$display("Checked %0d results from %0d samples under %0d register settings",
			n_checked, n_samples, n_settings);
		$display("Zone hits mid %0d r %0d l %0d f %0d b %0d rf %0d lf %0d rb %0d lb %0d",
			zone_hits[0], zone_hits[1], zone_hits[2], zone_hits[3], zone_hits[4],
			zone_hits[5], zone_hits[6], zone_hits[7], zone_hits[8]);
		if (n_err == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Mismatches: %0d", n_err);
			$display("Verification failed");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("Timeout with %0d results pending", expected_q.size());
		$display("Verification failed");
		$finish;
	end

endmodule
